// ----- hw/rtl/ifp_pkg.sv -----
`timescale 1ns / 1ps
// ifp_pkg: shared types and constants for the imu frame parser and scaler
// no dependencies; imported by every module of the block
package ifp_pkg;

	// frame markers
	localparam logic [7:0] HDR_FIRST = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'hBB;
	localparam logic [7:0] TRL_FIRST = 8'hCC;
	localparam logic [7:0] TRL_SECOND = 8'hDD;

	// frame layout, in byte positions
	localparam int MIN_FRAME_BYTES = 20;
	localparam int CNT_FIRST = 2;
	localparam int SMP_FIRST = 6;
	localparam int SMP_END = 18;
	localparam int NUM_SAMPLES = 6;

	// back end sequencing: one timestamp product then six sample products
	localparam int NUM_PRODUCTS = 7;
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_TIME = 3'd0;
	localparam logic [STEP_W-1:0] STEP_LAST = 3'(NUM_PRODUCTS - 1);
	localparam logic [STEP_W-1:0] STEP_GYRO = 3'd4;

	localparam int QUEUE_DEPTH = 2;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_LENGTH = 3'd0,
		REG_LITTLE_ENDIAN = 3'd1,
		REG_TIME_STEP = 3'd2,
		REG_ACCEL_GAIN = 3'd3,
		REG_GYRO_GAIN = 3'd4
	} reg_idx_t;

	localparam logic [6:0] RST_FRAME_LENGTH = 7'd20;
	localparam logic RST_LITTLE_ENDIAN = 1'b1;
	localparam logic [31:0] RST_TIME_STEP = 32'd42949673;
	localparam logic [31:0] RST_GAIN = 32'h0100_0000;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_SECOND = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		logic [6:0] frame_length;
		logic little_endian;
	} front_cfg_t;

	typedef struct packed {
		logic [31:0] time_step;
		logic [31:0] accel_gain;
		logic [31:0] gyro_gain;
	} back_cfg_t;

	// one parsed frame as it travels through the queue
	typedef struct packed {
		logic [31:0] counter;
		logic [NUM_SAMPLES-1:0][15:0] samples;
	} frame_t;

	typedef struct packed {
		logic [63:0] timestamp;
		logic [31:0] frame_counter;
		logic [NUM_SAMPLES-1:0][31:0] scaled;
	} result_t;

endpackage

// ----- hw/rtl/ifp_front.sv -----
`timescale 1ns / 1ps
// ifp_front: byte-wise header hunt, field assembly and trailer check
// depends on ifp_pkg; pushes one complete frame per good trailer
module ifp_front #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input logic clk,
	input logic arst_n,
	input ifp_pkg::front_cfg_t cfg,
	input logic in_fire,
	input logic [7:0] rx_byte,
	output logic push,
	output ifp_pkg::frame_t frame
);
	import ifp_pkg::*;

	localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CW = (PW > 7) ? PW : 7;

	phase_t phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [31:0] cnt_q, cnt_d;
	logic tseen_q, tseen_d;
	logic [15:0] raw_q [NUM_SAMPLES];

	logic [CW-1:0] fl_w;
	logic [PW-1:0] len;
	logic last_byte, trail_first;
	logic in_cnt, in_smp;
	logic [PW-1:0] cnt_off, smp_off;
	logic [1:0] cnt_lane;
	logic [2:0] smp_idx;
	logic smp_lane;
	logic smp_we;

	// effective frame length, clamped to the supported range
	always_comb begin
		fl_w = CW'(cfg.frame_length);
		if (fl_w < CW'(MIN_FRAME_BYTES)) begin
			len = PW'(MIN_FRAME_BYTES);
		end else if (fl_w > CW'(MAX_FRAME_BYTES)) begin
			len = PW'(MAX_FRAME_BYTES);
		end else begin
			len = PW'(fl_w);
		end
	end

	assign last_byte = ({1'b0, pos_q} + (PW+1)'(1)) >= {1'b0, len};
	assign trail_first = ({1'b0, pos_q} + (PW+1)'(2)) == {1'b0, len};
	assign in_cnt = (pos_q >= PW'(CNT_FIRST)) && (pos_q < PW'(SMP_FIRST));
	assign in_smp = (pos_q >= PW'(SMP_FIRST)) && (pos_q < PW'(SMP_END));
	assign cnt_off = pos_q - PW'(CNT_FIRST);
	assign smp_off = pos_q - PW'(SMP_FIRST);
	assign cnt_lane = cfg.little_endian ? cnt_off[1:0] : ~cnt_off[1:0];
	assign smp_idx = smp_off[3:1];
	assign smp_lane = cfg.little_endian ? smp_off[0] : ~smp_off[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q <= '0;
			cnt_q <= '0;
			tseen_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			cnt_q <= cnt_d;
			tseen_q <= tseen_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		cnt_d = cnt_q;
		tseen_d = tseen_q;
		push = 1'b0;
		smp_we = 1'b0;
		if (in_fire) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == HDR_FIRST) begin
						phase_d = PH_SECOND;
					end
				end
				PH_SECOND: begin
					if (rx_byte == HDR_SECOND) begin
						phase_d = PH_BODY;
						pos_d = PW'(CNT_FIRST);
						cnt_d = '0;
						tseen_d = 1'b0;
					end else if (rx_byte != HDR_FIRST) begin
						phase_d = PH_HUNT;
					end
				end
				PH_BODY: begin
					if (last_byte) begin
						phase_d = PH_HUNT;
						pos_d = '0;
						push = tseen_q && (rx_byte == TRL_SECOND);
					end else begin
						if (trail_first) begin
							tseen_d = (rx_byte == TRL_FIRST);
						end else if (in_cnt) begin
							cnt_d[cnt_lane*8 +: 8] = rx_byte;
						end else if (in_smp) begin
							smp_we = 1'b1;
						end
						pos_d = pos_q + PW'(1);
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (smp_we) begin
			raw_q[smp_idx][smp_lane*8 +: 8] <= rx_byte;
		end
	end

	always_comb begin
		frame.counter = cnt_q;
		for (int i = 0; i < NUM_SAMPLES; i++) begin
			frame.samples[i] = raw_q[i];
		end
	end

endmodule

// ----- hw/rtl/ifp_queue.sv -----
`timescale 1ns / 1ps
// ifp_queue: short frame queue between the parser and the arithmetic back end
// depends on ifp_pkg for the frame type and depth
module ifp_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input ifp_pkg::frame_t din,
	input logic pop,
	output ifp_pkg::frame_t head,
	output logic empty,
	output logic full
);
	import ifp_pkg::*;

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	frame_t mem_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_q, rd_q;
	logic [QCW-1:0] count_q;

	function automatic logic [QPW-1:0] bump(input logic [QPW-1:0] p);
		logic [QPW-1:0] n;
		n = (p == QPW'(QUEUE_DEPTH - 1)) ? '0 : p + QPW'(1);
		return n;
	endfunction

	assign empty = (count_q == '0);
	assign full = (count_q == QCW'(QUEUE_DEPTH));
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// ----- hw/rtl/ifp_back.sv -----
`timescale 1ns / 1ps
// ifp_back: timestamp and sample scaling on one shared 33x33 multiplier
// depends on ifp_pkg; pops frames from ifp_queue, holds the result register
module ifp_back (
	input logic clk,
	input logic arst_n,
	input ifp_pkg::back_cfg_t cfg,
	input logic q_empty,
	input ifp_pkg::frame_t q_head,
	output logic q_pop,
	output logic out_valid,
	input logic out_ready,
	output ifp_pkg::result_t res
);
	import ifp_pkg::*;

	frame_t frame_q;
	logic iss_q;
	logic [STEP_W-1:0] step_q;
	logic v_s1;
	logic [STEP_W-1:0] step_s1;
	logic signed [65:0] mul_s1;
	logic out_valid_q;
	result_t res_q;

	logic signed [32:0] op_a, op_b;
	logic [STEP_W-1:0] sidx;
	logic [STEP_W-1:0] widx;
	logic [31:0] gain;

	// q24.24 product to q16.16, round half up, saturate
	function automatic logic [31:0] round_sat(input logic signed [65:0] p);
		logic signed [48:0] x;
		logic signed [40:0] q;
		logic [31:0] r;
		x = $signed(p[48:0]) + 49'sd128;
		q = $signed(x[48:8]);
		if (q > 41'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (q < -41'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = q[31:0];
		end
		return r;
	endfunction

	assign q_pop = !q_empty && !iss_q && !v_s1 && (!out_valid_q || out_ready);

	assign sidx = step_q - STEP_W'(1);
	assign widx = step_s1 - STEP_W'(1);
	assign gain = (step_q >= STEP_GYRO) ? cfg.gyro_gain : cfg.accel_gain;

	always_comb begin
		if (step_q == STEP_TIME) begin
			op_a = $signed({1'b0, frame_q.counter});
			op_b = $signed({1'b0, cfg.time_step});
		end else begin
			op_a = $signed({{17{frame_q.samples[sidx][15]}}, frame_q.samples[sidx]});
			op_b = $signed({gain[31], gain});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= 1'b0;
			step_q <= '0;
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				iss_q <= 1'b1;
				step_q <= STEP_TIME;
			end else if (iss_q) begin
				if (step_q == STEP_LAST) begin
					iss_q <= 1'b0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			v_s1 <= iss_q;
			if (v_s1 && step_s1 == STEP_LAST) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			frame_q <= q_head;
		end
		mul_s1 <= op_a * op_b;
		step_s1 <= step_q;
		if (v_s1) begin
			if (step_s1 == STEP_TIME) begin
				res_q.timestamp <= mul_s1[63:0];
				res_q.frame_counter <= frame_q.counter;
			end else begin
				res_q.scaled[widx] <= round_sat(mul_s1);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res = res_q;

endmodule

// ----- hw/rtl/imu_frame_parser_scaler.sv -----
`timescale 1ns / 1ps
// imu_frame_parser_scaler: top level, configuration registers and assertions
// depends on ifp_pkg, ifp_front, ifp_queue and ifp_back
//
//   channel  signals                      direction  meaning
//   in       in_valid/in_ready, rx_byte   sink       one received byte per item
//   out      out_valid/out_ready, fields  source     one scaled frame per item
//   cfg      cfg_we, cfg_index, cfg_data  sink       register write, no wait
//
// the parser takes one byte per cycle; in_ready falls only while both queue
// entries hold frames that the back end has not started
// the back end runs seven products of a popped frame on one shared 33x33
// multiplier, one per cycle, then a round and saturate stage; a new frame
// starts after the products drain and the result register is free or being taken
// reset is asynchronous and clears control state at once; no clearing pass
module imu_frame_parser_scaler #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [63:0] timestamp,
	output logic [31:0] frame_counter,
	output logic signed [31:0] accel_x,
	output logic signed [31:0] accel_y,
	output logic signed [31:0] accel_z,
	output logic signed [31:0] rate_x,
	output logic signed [31:0] rate_y,
	output logic signed [31:0] rate_z,
	input logic cfg_we,
	input logic [ifp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ifp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ifp_pkg::*;

	front_cfg_t fcfg_q;
	back_cfg_t bcfg_q;
	logic q_push, q_pop, q_full, q_empty;
	frame_t push_frame, head_frame;
	result_t res;
	logic in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcfg_q.frame_length <= RST_FRAME_LENGTH;
			fcfg_q.little_endian <= RST_LITTLE_ENDIAN;
			bcfg_q.time_step <= RST_TIME_STEP;
			bcfg_q.accel_gain <= RST_GAIN;
			bcfg_q.gyro_gain <= RST_GAIN;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_LENGTH: fcfg_q.frame_length <= cfg_data[6:0];
				REG_LITTLE_ENDIAN: fcfg_q.little_endian <= cfg_data[0];
				REG_TIME_STEP: bcfg_q.time_step <= cfg_data;
				REG_ACCEL_GAIN: bcfg_q.accel_gain <= cfg_data;
				REG_GYRO_GAIN: bcfg_q.gyro_gain <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !q_full;
	assign in_fire = in_valid && in_ready;

	ifp_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(fcfg_q),
		.in_fire(in_fire),
		.rx_byte(rx_byte),
		.push(q_push),
		.frame(push_frame)
	);

	ifp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.din(push_frame),
		.pop(q_pop),
		.head(head_frame),
		.empty(q_empty),
		.full(q_full)
	);

	ifp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(bcfg_q),
		.q_empty(q_empty),
		.q_head(head_frame),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res(res)
	);

	assign timestamp = res.timestamp;
	assign frame_counter = res.frame_counter;
	assign accel_x = $signed(res.scaled[0]);
	assign accel_y = $signed(res.scaled[1]);
	assign accel_z = $signed(res.scaled[2]);
	assign rate_x = $signed(res.scaled[3]);
	assign rate_y = $signed(res.scaled[4]);
	assign rate_z = $signed(res.scaled[5]);

	// a finished frame never lands on a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("frame pushed into a full queue");

	// a frame leaves the queue only when the result register is free or draining
	a_pop_slot: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!out_valid || out_ready))
		else $error("frame popped while the result is still held");

	// every new result traces back to an earlier pop from the frame queue
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_pop, 9))
		else $error("result appeared without a matching pop");

endmodule
